/* hdl/brs_pkg.sv */
// brs_pkg: shared types and constants of the bitmap range set/clear block
// no dependencies; used by the word unit and the top level
package brs_pkg;

    localparam int START_W = 10;
    localparam int COUNT_W = 11;
    localparam int SIZE_W  = 11;
    localparam int HI_W    = 12;

    localparam logic [SIZE_W-1:0] CFG_SIZE_RESET = 11'd1024;

    localparam logic OP_SET   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // one request as seen by the word unit
    typedef struct packed {
        logic              clear;
        logic              apply;
        logic [START_W-1:0] lo;
        logic [HI_W-1:0]    hi;
        logic [SIZE_W-1:0]  size;
    } t_range_ctl;

    // per-word check result
    typedef struct packed {
        logic empty;
        logic full;
    } t_word_stat;

endpackage

/* hdl/brs_if.sv */
// brs_if: valid/ready channel interfaces of the bitmap range set/clear block
// request, response and map size configuration; no dependencies
interface brs_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [9:0] range_start;
    logic [10:0] range_count;

    modport source (output valid, output op, output range_start, output range_count,
                    input ready);
    modport sink   (input valid, input op, input range_start, input range_count,
                    output ready);
endinterface

interface brs_rsp_if;
    logic valid;
    logic ready;
    logic is_empty;
    logic is_full;
    logic range_error;

    modport source (output valid, output is_empty, output is_full, output range_error,
                    input ready);
    modport sink   (input valid, input is_empty, input is_full, input range_error,
                    output ready);
endinterface

interface brs_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] map_size;

    modport source (output valid, output map_size, input ready);
    modport sink   (input valid, input map_size, output ready);
endinterface

/* hdl/brs_ram.sv */
// brs_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module brs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/brs_word_unit.sv */
// brs_word_unit: masks one map word against the request range and checks it
// against the map size; uses brs_pkg
module brs_word_unit #(
    parameter int WORD_BITS = 32,
    parameter int BASE_W    = 11
) (
    input  brs_pkg::t_range_ctl i_ctl,
    input  logic [BASE_W-1:0]   i_base,
    input  logic [WORD_BITS-1:0] i_rd_word,
    output logic [WORD_BITS-1:0] o_wr_word,
    output brs_pkg::t_word_stat o_stat
);

    localparam int OFF_W  = $clog2(WORD_BITS + 1);
    localparam int WIDE_W = (BASE_W > brs_pkg::HI_W) ? BASE_W : brs_pkg::HI_W;
    localparam int DIFF_W = WIDE_W + 1;

    logic signed [DIFF_W-1:0] s_base;
    logic signed [DIFF_W-1:0] d_lo;
    logic signed [DIFF_W-1:0] d_hi;
    logic signed [DIFF_W-1:0] d_size;
    logic [OFF_W-1:0]         off_lo;
    logic [OFF_W-1:0]         off_hi;
    logic [OFF_W-1:0]         off_size;
    logic [WORD_BITS-1:0]     range_mask;
    logic [WORD_BITS-1:0]     chk_mask;

    // offset of a bit position inside this word, clamped to [0, WORD_BITS]
    function automatic logic [OFF_W-1:0] clamp_off(input logic signed [DIFF_W-1:0] d);
        logic [OFF_W-1:0] r;
        if (d <= 0) begin
            r = '0;
        end else if (d >= WORD_BITS) begin
            r = OFF_W'(WORD_BITS);
        end else begin
            r = d[OFF_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        s_base   = $signed(DIFF_W'(i_base));
        d_lo     = $signed(DIFF_W'(i_ctl.lo)) - s_base;
        d_hi     = $signed(DIFF_W'(i_ctl.hi)) - s_base;
        d_size   = $signed(DIFF_W'(i_ctl.size)) - s_base;
        off_lo   = clamp_off(d_lo);
        off_hi   = clamp_off(d_hi);
        off_size = clamp_off(d_size);
        for (int j = 0; j < WORD_BITS; j++) begin
            range_mask[j] = i_ctl.apply && (OFF_W'(j) >= off_lo) && (OFF_W'(j) < off_hi);
            chk_mask[j]   = OFF_W'(j) < off_size;
        end
        if (i_ctl.clear == brs_pkg::OP_CLEAR) begin
            o_wr_word = i_rd_word & ~range_mask;
        end else begin
            o_wr_word = i_rd_word | range_mask;
        end
        o_stat.empty = (o_wr_word & chk_mask) == '0;
        o_stat.full  = (o_wr_word | ~chk_mask) == '1;
    end

endmodule

/* hdl/bitmap_range_set_clear.sv */
// Bitmap range set/clear. The map is held as ceil(MAP_BITS/WORD_BITS) words in a
// single RAM and one word unit walks it a word per cycle: each request reads every
// word, masks the part of the range that falls in it, writes it back and folds it
// into the empty/full check of the first map_size bits. A request holds the
// block through its walk and the done state; the next is taken only back in idle,
// and the done state waits while the output register holds an untaken response.
// After reset a clearing pass zeroes the RAM word by word; requests wait until it
// ends, configuration writes are taken at any time. map_size above MAP_BITS acts as
// MAP_BITS. A range reaching past map_size leaves the map as it is and reports
// range_error. The response waits in an output register until taken.
// depends on brs_pkg, brs_if, brs_ram and brs_word_unit
module bitmap_range_set_clear #(
    parameter int MAP_BITS  = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    brs_req_if.sink      i_req,
    brs_rsp_if.source    o_rsp,
    brs_cfg_if.sink      i_cfg
);

    localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_W     = $clog2(NUM_WORDS + 1);
    localparam int BASE_W    = $clog2(NUM_WORDS * WORD_BITS + 1);
    localparam int MB_W      = $clog2(MAP_BITS + 1);
    localparam int SZ_W      = (MB_W > brs_pkg::SIZE_W) ? MB_W : brs_pkg::SIZE_W;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RUN, S_DONE} t_state;

    t_state                       r_state;
    logic [brs_pkg::SIZE_W-1:0]   r_cfg_size;
    brs_pkg::t_range_ctl          r_ctl;
    logic                         r_err;
    logic [CNT_W-1:0]             r_rd_w;
    logic                         r_rd_busy;
    logic                         r_s2_valid;
    logic [ADDR_W-1:0]            r_s2_w;
    logic [BASE_W-1:0]            r_s2_base;
    logic                         r_acc_empty;
    logic                         r_acc_full;
    logic                         r_out_valid;
    logic                         r_out_empty;
    logic                         r_out_full;
    logic                         r_out_err;

    logic                         req_fire;
    logic                         cfg_fire;
    logic                         out_fire;
    logic [brs_pkg::SIZE_W-1:0]   eff_size;
    logic [brs_pkg::HI_W-1:0]     range_end;
    logic                         req_err;
    brs_pkg::t_range_ctl          req_ctl;
    logic                         rd_last;
    logic                         ram_wr_en;
    logic [ADDR_W-1:0]            ram_wr_addr;
    logic [WORD_BITS-1:0]         ram_wr_data;
    logic                         ram_rd_en;
    logic [WORD_BITS-1:0]         ram_rd_data;
    logic [WORD_BITS-1:0]         unit_word;
    brs_pkg::t_word_stat          unit_stat;

    assign req_fire = i_req.valid && i_req.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign out_fire = r_out_valid && o_rsp.ready;

    // request decode: limit check against the saturated map size
    always_comb begin
        if (SZ_W'(r_cfg_size) > SZ_W'(MAP_BITS)) begin
            eff_size = brs_pkg::SIZE_W'(MAP_BITS);
        end else begin
            eff_size = r_cfg_size;
        end
        range_end     = brs_pkg::HI_W'(i_req.range_start) + brs_pkg::HI_W'(i_req.range_count);
        req_err       = range_end > brs_pkg::HI_W'(eff_size);
        req_ctl.clear = i_req.op;
        req_ctl.apply = !req_err && (i_req.range_count != '0);
        req_ctl.lo    = i_req.range_start;
        req_ctl.hi    = range_end;
        req_ctl.size  = eff_size;
    end

    assign rd_last = r_rd_w == CNT_W'(NUM_WORDS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cfg_size  <= brs_pkg::CFG_SIZE_RESET;
            r_rd_w      <= '0;
            r_rd_busy   <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_fire) begin
                r_cfg_size <= i_cfg.map_size;
            end
            // a response taken in the done cycle is replaced by the new one
            if (out_fire && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            r_s2_valid <= (r_state == S_RUN) && r_rd_busy;
            unique case (r_state)
                S_CLEAR: begin
                    r_rd_w <= r_rd_w + 1'b1;
                    if (rd_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (req_fire) begin
                        r_ctl       <= req_ctl;
                        r_err       <= req_err;
                        r_rd_w      <= '0;
                        r_rd_busy   <= 1'b1;
                        r_s2_base   <= '0;
                        r_acc_empty <= 1'b1;
                        r_acc_full  <= 1'b1;
                        r_state     <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_rd_busy) begin
                        r_rd_w     <= r_rd_w + 1'b1;
                        r_s2_w     <= r_rd_w[ADDR_W-1:0];
                        if (rd_last) begin
                            r_rd_busy <= 1'b0;
                        end
                    end
                    // word read last cycle is updated and checked now
                    if (r_s2_valid) begin
                        r_s2_base   <= r_s2_base + BASE_W'(WORD_BITS);
                        r_acc_empty <= r_acc_empty & unit_stat.empty;
                        r_acc_full  <= r_acc_full & unit_stat.full;
                        if (r_s2_w == ADDR_W'(NUM_WORDS - 1)) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_empty <= r_acc_empty;
                        r_out_full  <= r_acc_full;
                        r_out_err   <= r_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign ram_rd_en   = (r_state == S_RUN) && r_rd_busy;
    assign ram_wr_en   = (r_state == S_CLEAR) || ((r_state == S_RUN) && r_s2_valid && r_ctl.apply);
    assign ram_wr_addr = (r_state == S_CLEAR) ? r_rd_w[ADDR_W-1:0] : r_s2_w;
    assign ram_wr_data = (r_state == S_CLEAR) ? '0 : unit_word;

    brs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_rd_w[ADDR_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    brs_word_unit #(
        .WORD_BITS (WORD_BITS),
        .BASE_W    (BASE_W)
    ) u_word_unit (
        .i_ctl     (r_ctl),
        .i_base    (r_s2_base),
        .i_rd_word (ram_rd_data),
        .o_wr_word (unit_word),
        .o_stat    (unit_stat)
    );

    assign i_req.ready       = r_state == S_IDLE;
    assign i_cfg.ready       = 1'b1;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.is_empty    = r_out_empty;
    assign o_rsp.is_full     = r_out_full;
    assign o_rsp.range_error = r_out_err;

endmodule

/* hdl/brs_checker.sv */
// brs_checker: port-level assertions for the bitmap range set/clear block
// bound to bitmap_range_set_clear; no package dependencies
module brs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input logic i_rsp_is_empty,
    input logic i_rsp_is_full,
    input logic i_rsp_range_error
);

    // clearing pass keeps requests out right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_req_ready)
        else $error("request ready during clearing pass");

    // one request at a time
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request ready right after a request was taken");

    // a response only appears at the end of the walk, never while idle
    a_rsp_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(!i_req_ready))
        else $error("response raised while block was idle");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_is_empty) && $stable(i_rsp_is_full)
             && $stable(i_rsp_range_error)))
        else $error("stalled response changed");

endmodule

bind bitmap_range_set_clear brs_checker u_brs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_is_empty    (o_rsp.is_empty),
    .i_rsp_is_full     (o_rsp.is_full),
    .i_rsp_range_error (o_rsp.range_error)
);
